[src/nvp_pkg.sv]
package nvp_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 32;
  localparam int unsigned MulSteps = MulBW / DigitW;

  localparam logic [31:0] Q31One       = 32'h8000_0000;
  localparam logic [30:0] DecayPerStep = 31'd1958535031;

  localparam logic [1:0] CFG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE   = 2'd1;
  localparam logic [1:0] CFG_STEP_PERIOD = 2'd2;

endpackage

[src/nonlinear_velocity_profile.sv]
// channel  | handshake                      | words
// ---------+--------------------------------+------------------------------------------
// input    | in_valid_i / in_ready_o        | mode_i, target_offset_i, initial_velocity_i
// output   | out_valid_o / out_ready_i      | velocity_o, sample_valid_o, profile_last_o
// config   | cfg_we_i (no wait)             | cfg_idx_i, cfg_data_i
//
// One word at a time. A start word or a tick while idle goes from S_IDLE
// through S_DONE to the output register. A running tick runs the restoring
// index division, one table read, then four passes through the shared
// 4-bit serial multiplier, a check and the hand-off. Reset is asynchronous
// and clears all state but the output data; the output register holds
// while out_ready_i is low and the next word may be taken meanwhile.
module nonlinear_velocity_profile
  import nvp_pkg::*;
#(
  parameter int unsigned GAMMA_TABLE_ENTRIES = 256,
  parameter int unsigned FRACTION_BITS       = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] target_offset_i,
  input  logic signed [31:0] initial_velocity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] velocity_o,
  output logic               sample_valid_o,
  output logic               profile_last_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);

  localparam int unsigned IdxW = $clog2(GAMMA_TABLE_ENTRIES);
  localparam logic [30:0] SpeedReset =
    31'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] TolReset =
    31'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic [16:0] StepReset =
    17'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] TimeLimit = 32'(64'd5 << FRACTION_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ROM, S_GAIN, S_STEP, S_DIST, S_DECAY, S_CHECK, S_DONE
  } state_e;

  state_e state_q;

  logic [30:0] speed_q, tol_q;
  logic [16:0] step_q;
  logic signed [31:0] goal_q, start_q, trav_q, vel_q;
  logic [31:0] elapsed_q, decay_q;
  logic        running_q;
  logic signed [33:0] diff_q;
  logic        res_sv_q, res_last_q;
  logic        out_valid_q, out_sv_q, out_last_q;
  logic signed [31:0] out_vel_q;
  logic        div_start_q, mul_start_q;
  logic [MulAW-1:0] mul_a_q;
  logic [MulBW-1:0] mul_b_q;

  logic [30:0] tol_eff;
  logic signed [32:0] rel_w;
  logic [32:0] psi_w, goal_abs;
  logic        div_done;
  logic [IdxW-1:0] idx_w;
  logic [30:0] gamma_w;
  logic        mul_done;
  logic [MulAW+MulBW-1:0] prod_w;

  logic signed [33:0] target_w, diff_w, delta_w, vsum_w;
  logic [32:0] mag_w, vabs_w;
  logic signed [31:0] v_w;
  logic signed [51:0] pmag_w, dist_w, shift_w, tsum_w;
  logic signed [31:0] trav_d;
  logic [32:0] el_sum;
  logic [31:0] elapsed_d;
  logic [63:0] drnd_w;

  assign tol_eff  = (tol_q == '0) ? 31'd1 : tol_q;
  assign rel_w    = 33'(trav_q) - 33'(goal_q);
  assign psi_w    = rel_w[32] ? 33'(-rel_w) : 33'(rel_w);
  assign goal_abs = target_offset_i[31] ? 33'(-33'(target_offset_i))
                                        : 33'(target_offset_i);

  assign target_w = (goal_q > 0) ? $signed({3'b0, prod_w[61:31]})
                  : (goal_q < 0) ? -$signed({3'b0, prod_w[61:31]}) : 34'sd0;
  assign diff_w   = target_w - 34'(start_q);
  assign mag_w    = prod_w[63:31];
  assign delta_w  = diff_q[33] ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
  assign vsum_w   = 34'(start_q) + delta_w;
  assign v_w      = vsum_w[31:0];
  assign vabs_w   = v_w[31] ? 33'(-33'(v_w)) : 33'(v_w);

  assign pmag_w  = $signed({1'b0, prod_w[50:0]});
  assign dist_w  = vel_q[31] ? -pmag_w : pmag_w;
  assign shift_w = dist_w >>> FRACTION_BITS;
  assign tsum_w  = shift_w + 52'(trav_q);
  assign trav_d  = (tsum_w > $signed(52'h0_0000_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                 : (tsum_w < -$signed(52'h0_0000_8000_0000)) ? 32'sh8000_0000
                 : tsum_w[31:0];
  assign el_sum    = {1'b0, elapsed_q} + 33'(step_q);
  assign elapsed_d = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  assign drnd_w    = prod_w[63:0] + 64'h4000_0000;

  nvp_idx_div #(.IdxW(IdxW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .psi_i   (psi_w),
    .tol_i   (tol_eff),
    .done_o  (div_done),
    .idx_o   (idx_w)
  );

  nvp_gamma_rom #(.Entries(GAMMA_TABLE_ENTRIES)) u_rom (
    .clk_i  (clk_i),
    .addr_i (idx_w),
    .data_o (gamma_w)
  );

  nvp_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (prod_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      speed_q     <= SpeedReset;
      tol_q       <= TolReset;
      step_q      <= StepReset;
      goal_q      <= '0;
      start_q     <= '0;
      trav_q      <= '0;
      elapsed_q   <= '0;
      decay_q     <= Q31One;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      res_sv_q    <= 1'b0;
      res_last_q  <= 1'b0;
      vel_q       <= '0;
      diff_q      <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPEED_LIMIT: speed_q <= cfg_data_i;
          CFG_TOLERANCE:   tol_q   <= cfg_data_i;
          CFG_STEP_PERIOD: step_q  <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vel_q      <= '0;
            res_sv_q   <= 1'b0;
            res_last_q <= 1'b0;
            if (mode_i) begin
              goal_q    <= target_offset_i;
              start_q   <= initial_velocity_i;
              trav_q    <= '0;
              elapsed_q <= '0;
              decay_q   <= Q31One;
              running_q <= goal_abs > 33'(tol_eff);
              state_q   <= S_DONE;
            end else if (!running_q) begin
              state_q <= S_DONE;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ROM;
          end
        end
        S_ROM: begin
          mul_a_q     <= 33'(gamma_w);
          mul_b_q     <= 32'(speed_q);
          mul_start_q <= 1'b1;
          state_q     <= S_GAIN;
        end
        S_GAIN: begin
          if (mul_done) begin
            diff_q      <= diff_w;
            mul_a_q     <= diff_w[33] ? 33'(-diff_w) : 33'(diff_w);
            mul_b_q     <= Q31One - decay_q;
            mul_start_q <= 1'b1;
            state_q     <= S_STEP;
          end
        end
        S_STEP: begin
          if (mul_done) begin
            vel_q       <= v_w;
            mul_a_q     <= vabs_w;
            mul_b_q     <= 32'(step_q);
            mul_start_q <= 1'b1;
            state_q     <= S_DIST;
          end
        end
        S_DIST: begin
          if (mul_done) begin
            trav_q      <= trav_d;
            elapsed_q   <= elapsed_d;
            mul_a_q     <= 33'(decay_q);
            mul_b_q     <= 32'(DecayPerStep);
            mul_start_q <= 1'b1;
            state_q     <= S_DECAY;
          end
        end
        S_DECAY: begin
          if (mul_done) begin
            decay_q <= drnd_w[62:31];
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          running_q  <= (psi_w > 33'(tol_eff)) && (elapsed_q < TimeLimit);
          res_sv_q   <= 1'b1;
          res_last_q <= !((psi_w > 33'(tol_eff)) && (elapsed_q < TimeLimit));
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_vel_q  <= vel_q;
      out_sv_q   <= res_sv_q;
      out_last_q <= res_last_q;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign velocity_o     = out_vel_q;
  assign sample_valid_o = out_sv_q;
  assign profile_last_o = out_last_q;

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> velocity_o == '0 && !profile_last_o)
    else $error("word without sample carries data");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

  a_decay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decay_q <= Q31One)
    else $error("decay factor above one");

endmodule

[src/nvp_gamma_rom.sv]
module nvp_gamma_rom #(
  parameter int unsigned Entries = 256
) (
  input  logic                       clk_i,
  input  logic [$clog2(Entries)-1:0] addr_i,
  output logic [30:0]                data_o
);

  localparam logic [63:0] GammaDen = 64'(25 * Entries * Entries);
  localparam logic [63:0] Q31      = 64'h8000_0000;

  function automatic logic [30:0] gamma_entry(input logic [63:0] i);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] e;
    y  = ((i * i) << 30) / GammaDen;
    y2 = (y * y) >> 31;
    y3 = (y2 * y) >> 31;
    e  = Q31 - y + (y2 >> 1) - y3 / 64'd6;
    for (int k = 0; k < 10; k++) begin
      e = (e * e + 64'h4000_0000) >> 31;
    end
    return 31'(Q31 - e);
  endfunction

  logic [30:0] rom_w [Entries];
  logic [30:0] data_q;

  for (genvar g = 0; g < Entries; g++) begin : g_rom
    assign rom_w[g] = gamma_entry(64'(g));
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

[src/nvp_idx_div.sv]
module nvp_idx_div #(
  parameter int unsigned IdxW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [32:0]     psi_i,
  input  logic [30:0]     tol_i,
  output logic            done_o,
  output logic [IdxW-1:0] idx_o
);

  localparam int unsigned CntW = $clog2(IdxW + 1);

  logic [36:0]     den_q;
  logic [37:0]     rem_q, rem_d, rem_sh;
  logic [IdxW-1:0] quo_q;
  logic            clamp_q;
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic            bit_w;

  assign rem_sh = {rem_q[36:0], 1'b0};
  assign bit_w  = rem_sh >= {1'b0, den_q};
  assign rem_d  = bit_w ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(IdxW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q   <= {tol_i, 6'b0};
      rem_q   <= {5'b0, psi_i};
      quo_q   <= '0;
      clamp_q <= {4'b0, psi_i} >= {tol_i, 6'b0};
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[IdxW-2:0], bit_w};
    end
  end

  assign done_o = done_q;
  assign idx_o  = clamp_q ? {IdxW{1'b1}} : quo_q;

endmodule

[src/nvp_serial_mul.sv]
module nvp_serial_mul
  import nvp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [MulAW-1:0]       a_i,
  input  logic [MulBW-1:0]       b_i,
  output logic                   done_o,
  output logic [MulAW+MulBW-1:0] prod_o
);

  localparam int unsigned PW   = MulAW + MulBW + DigitW;
  localparam int unsigned CntW = $clog2(MulSteps + 1);

  logic [MulAW-1:0]        a_q;
  logic [MulBW-1:0]        b_q;
  logic [PW-1:0]           p_q, p_sum;
  logic [MulAW+DigitW-1:0] pp_w;
  logic                    busy_q, done_q;
  logic [CntW-1:0]         cnt_q;

  assign pp_w  = a_q * b_q[DigitW-1:0];
  assign p_sum = p_q + {pp_w, {MulBW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MulSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      b_q <= b_q >> DigitW;
      p_q <= p_sum >> DigitW;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q[MulAW+MulBW-1:0];

endmodule
